@@ src/breakpoint_interpolate_add_gain_macros.svh @@
// assertion helpers shared by the rtl
`ifndef BREAKPOINT_INTERPOLATE_ADD_GAIN_MACROS_SVH
`define BREAKPOINT_INTERPOLATE_ADD_GAIN_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BPI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BPI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/bpi_pkg.sv @@
package bpi_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// field widths
	localparam int FREQ_W    = 16;
	localparam int LEVEL_W   = 16;
	localparam int DIV_STEPS = FREQ_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 16'sh7fff;
	localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		FN_CLEAR  = 2'd0,
		FN_APPEND = 2'd1,
		FN_QUERY  = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_FULL  = 3'd2,
		ST_ORDER = 3'd3,
		ST_SAT   = 3'd4
	} status_t;

	typedef struct packed {
		logic        [FREQ_W-1:0]  freq;
		logic signed [LEVEL_W-1:0] level;
	} bp_entry_t;

endpackage

@@ src/bpi_if.sv @@
// item channel: command, frequency, level
interface bpi_item_if import bpi_pkg::*; ();
	logic                      valid;
	logic                      ready;
	func_t                     func;
	logic        [FREQ_W-1:0]  freq;
	logic signed [LEVEL_W-1:0] level;

	modport source (output valid, func, freq, level, input ready);
	modport sink   (input valid, func, freq, level, output ready);
endinterface

// result channel: level and status
interface bpi_result_if import bpi_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [LEVEL_W-1:0] level_out;
	status_t                   status;

	modport source (output valid, level_out, status, input ready);
	modport sink   (input valid, level_out, status, output ready);
endinterface

@@ src/breakpoint_interpolate_add_gain.sv @@
// Breakpoint table with piecewise linear interpolation plus filter gain.
// item (valid/ready sink): func clears the table, appends a breakpoint
// (freq, level) or queries at freq with level taken as the filter gain.
// result (valid/ready source): one transfer per item, level_out and status.
// cfg_wr_en/cfg_wr_data write disable_filter_boost; write it only when idle.
// Breakpoints live in one synchronous single-port-read memory of
// TABLE_DEPTH entries; every step waits on its registered read.
// FN_NOP only returns a result. A query reads the first and last entries;
// at or beyond an end it takes that end's level, otherwise a binary search
// reads the midpoint per halving (S_SRCH_RD then S_SRCH_CMP); an exact hit
// skips interpolation, else a multiply and a restoring divide follow, and
// the divider retires one quotient bit per cycle.
// One item is in work at a time; item.ready is high while idle.
// The result sits in an output register, so a new item is taken while
// an earlier result waits; a stalled receiver holds the next finished
// result in the block until the register frees up.
// Reset empties the table (count cleared, memory contents left as is),
// clears disable_filter_boost and drops result.valid.
`include "breakpoint_interpolate_add_gain_macros.svh"

module breakpoint_interpolate_add_gain import bpi_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data,
	bpi_item_if.sink      item,
	bpi_result_if.source  result
);

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_APP_CHK  = 11'b000_0000_0010,
		S_Q_FIRST  = 11'b000_0000_0100,
		S_Q_LAST   = 11'b000_0000_1000,
		S_SRCH_RD  = 11'b000_0001_0000,
		S_SRCH_CMP = 11'b000_0010_0000,
		S_MUL      = 11'b000_0100_0000,
		S_DIV      = 11'b000_1000_0000,
		S_INTERP   = 11'b001_0000_0000,
		S_SUM      = 11'b010_0000_0000,
		S_DONE     = 11'b100_0000_0000
	} state_t;

	state_t                    state_q;
	logic                      boost_dis_q;
	logic        [CNT_W-1:0]   count_q;
	logic        [CNT_W-1:0]   count_m1;
	logic                      table_full;
	logic                      table_empty;
	logic                      item_xfer;
	logic                      slot_free;

	// breakpoint memory
	bp_entry_t                 mem [TABLE_DEPTH];
	bp_entry_t                 rd_q;
	bp_entry_t                 wr_data;
	logic                      mem_re;
	logic                      mem_we;
	logic        [ADDR_W-1:0]  rd_addr;
	logic        [ADDR_W-1:0]  wr_addr;

	// item and search registers
	func_t                     func_q;
	logic        [FREQ_W-1:0]  x_q;
	logic signed [LEVEL_W-1:0] gain_q;
	logic        [ADDR_W-1:0]  lo_q;
	logic        [ADDR_W-1:0]  hi_q;
	logic        [ADDR_W-1:0]  mid_q;
	logic        [ADDR_W-1:0]  mid;
	logic        [ADDR_W-1:0]  gap;
	logic                      gap_gt1;
	logic        [FREQ_W-1:0]  f_lo_q;
	logic        [FREQ_W-1:0]  f_hi_q;
	logic signed [LEVEL_W-1:0] y_lo_q;
	logic signed [LEVEL_W-1:0] y_hi_q;

	// interpolation datapath
	logic signed [LEVEL_W:0]   dy;
	logic        [LEVEL_W:0]   dy_mag;
	logic        [FREQ_W-1:0]  dx;
	logic        [2*FREQ_W-1:0] prod;
	logic                      neg_q;
	logic        [FREQ_W-1:0]  span_q;
	logic        [FREQ_W-1:0]  rem_q;
	logic        [FREQ_W-1:0]  quo_q;
	logic        [DIV_CNT_W-1:0] div_cnt_q;
	logic        [FREQ_W:0]    trial;
	logic                      trial_ge;
	logic        [FREQ_W:0]    trial_sub;
	logic signed [FREQ_W:0]    term;
	logic signed [LEVEL_W+1:0] interp_sum;
	logic signed [LEVEL_W-1:0] interp_q;
	logic signed [LEVEL_W-1:0] gain_eff;
	logic signed [LEVEL_W:0]   total;

	// result staging and output register
	logic signed [LEVEL_W-1:0] res_level_q;
	status_t                   res_status_q;
	logic                      out_valid_q;
	logic signed [LEVEL_W-1:0] out_level_q;
	status_t                   out_status_q;

	// handshake and table flags
	assign item.ready   = (state_q == S_IDLE);
	assign item_xfer    = item.valid && item.ready;
	assign slot_free    = !out_valid_q || result.ready;
	assign count_m1     = count_q - 1'b1;
	assign table_full   = (count_q == CNT_W'(TABLE_DEPTH));
	assign table_empty  = (count_q == '0);

	assign result.valid     = out_valid_q;
	assign result.level_out = out_level_q;
	assign result.status    = out_status_q;

	// search midpoint
	assign gap     = hi_q - lo_q;
	assign gap_gt1 = (gap > ADDR_W'(1));
	assign mid     = lo_q + (gap >> 1);

	// segment slope terms
	assign dy     = {y_hi_q[LEVEL_W-1], y_hi_q} - {y_lo_q[LEVEL_W-1], y_lo_q};
	assign dy_mag = dy[LEVEL_W] ? (LEVEL_W+1)'(-dy) : dy;
	assign dx     = x_q - f_lo_q;
	assign prod   = dy_mag[LEVEL_W-1:0] * dx;

	// one restoring division step
	assign trial     = {rem_q, quo_q[FREQ_W-1]};
	assign trial_ge  = (trial >= {1'b0, span_q});
	assign trial_sub = trial - {1'b0, span_q};

	// level at the query point and gain sum
	assign term       = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign interp_sum = (LEVEL_W+2)'(y_lo_q) + (LEVEL_W+2)'(term);
	assign gain_eff   = (boost_dis_q && (gain_q > 0)) ? '0 : gain_q;
	assign total      = (LEVEL_W+1)'(interp_q) + (LEVEL_W+1)'(gain_eff);

	// memory access control
	always_comb begin
		mem_re  = 1'b0;
		mem_we  = 1'b0;
		rd_addr = '0;
		wr_addr = count_q[ADDR_W-1:0];
		wr_data = '{freq: x_q, level: gain_q};
		unique case (state_q)
			S_IDLE: begin
				if (item_xfer && (item.func == FN_APPEND) && !table_full) begin
					mem_re  = 1'b1;
					rd_addr = count_m1[ADDR_W-1:0];
				end else if (item_xfer && (item.func == FN_QUERY) && !table_empty) begin
					mem_re  = 1'b1;
					rd_addr = '0;
				end
			end
			S_APP_CHK: begin
				mem_we = table_empty || (x_q > rd_q.freq);
			end
			S_Q_FIRST: begin
				mem_re  = 1'b1;
				rd_addr = count_m1[ADDR_W-1:0];
			end
			S_SRCH_RD: begin
				mem_re  = gap_gt1;
				rd_addr = mid;
			end
			S_SRCH_CMP, S_Q_LAST, S_MUL, S_DIV, S_INTERP, S_SUM, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// breakpoint storage, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rd_q <= mem[rd_addr];
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boost_dis_q <= 1'b0;
		end else if (cfg_wr_en) begin
			boost_dis_q <= cfg_wr_data;
		end
	end

	// sequencer, table count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_xfer) begin
						unique case (item.func)
							FN_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							FN_APPEND: state_q <= table_full ? S_DONE : S_APP_CHK;
							FN_QUERY:  state_q <= table_empty ? S_DONE : S_Q_FIRST;
							FN_NOP:    state_q <= S_DONE;
						endcase
					end
				end
				S_APP_CHK: begin
					if (mem_we) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_Q_FIRST: state_q <= S_Q_LAST;
				S_Q_LAST: begin
					if ((x_q <= f_lo_q) || (x_q >= rd_q.freq)) begin
						state_q <= S_SUM;
					end else begin
						state_q <= S_SRCH_RD;
					end
				end
				S_SRCH_RD: begin
					if (gap_gt1) begin
						state_q <= S_SRCH_CMP;
					end else if (f_lo_q == x_q) begin
						state_q <= S_SUM;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_SRCH_CMP: state_q <= S_SRCH_RD;
				S_MUL: begin
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_INTERP;
					end
				end
				S_INTERP: state_q <= S_SUM;
				S_SUM:    state_q <= S_DONE;
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && slot_free) begin
			out_level_q  <= res_level_q;
			out_status_q <= res_status_q;
		end
		unique case (state_q)
			S_IDLE: begin
				if (item_xfer) begin
					func_q      <= item.func;
					x_q         <= item.freq;
					gain_q      <= item.level;
					res_level_q <= '0;
					if ((item.func == FN_APPEND) && table_full) begin
						res_status_q <= ST_FULL;
					end else if ((item.func == FN_QUERY) && table_empty) begin
						res_status_q <= ST_EMPTY;
					end else begin
						res_status_q <= ST_OK;
					end
				end
			end
			S_APP_CHK: begin
				if (!mem_we) begin
					res_status_q <= ST_ORDER;
				end
			end
			S_Q_FIRST: begin
				lo_q   <= '0;
				f_lo_q <= rd_q.freq;
				y_lo_q <= rd_q.level;
			end
			S_Q_LAST: begin
				hi_q   <= count_m1[ADDR_W-1:0];
				f_hi_q <= rd_q.freq;
				y_hi_q <= rd_q.level;
				if (x_q <= f_lo_q) begin
					interp_q <= y_lo_q;
				end else begin
					interp_q <= rd_q.level;
				end
			end
			S_SRCH_RD: begin
				mid_q    <= mid;
				interp_q <= y_lo_q;
			end
			S_SRCH_CMP: begin
				if (rd_q.freq <= x_q) begin
					lo_q   <= mid_q;
					f_lo_q <= rd_q.freq;
					y_lo_q <= rd_q.level;
				end else begin
					hi_q   <= mid_q;
					f_hi_q <= rd_q.freq;
					y_hi_q <= rd_q.level;
				end
			end
			S_MUL: begin
				neg_q  <= dy[LEVEL_W];
				span_q <= f_hi_q - f_lo_q;
				rem_q  <= prod[2*FREQ_W-1:FREQ_W];
				quo_q  <= prod[FREQ_W-1:0];
			end
			S_DIV: begin
				rem_q <= trial_ge ? trial_sub[FREQ_W-1:0] : trial[FREQ_W-1:0];
				quo_q <= {quo_q[FREQ_W-2:0], trial_ge};
			end
			S_INTERP: begin
				interp_q <= interp_sum[LEVEL_W-1:0];
			end
			S_SUM: begin
				if (total > (LEVEL_W+1)'(LEVEL_MAX)) begin
					res_level_q  <= LEVEL_MAX;
					res_status_q <= ST_SAT;
				end else if (total < (LEVEL_W+1)'(LEVEL_MIN)) begin
					res_level_q  <= LEVEL_MIN;
					res_status_q <= ST_SAT;
				end else begin
					res_level_q  <= total[LEVEL_W-1:0];
					res_status_q <= ST_OK;
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// checks on table count, search window, divider and results
	`BPI_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(TABLE_DEPTH), "count above depth")
	`BPI_ASSERT_NEXT(a_write_bumps_count, mem_we, count_q == $past(count_q) + 1'b1, "count not bumped")
	`BPI_ASSERT_NOW(a_search_window, state_q == S_SRCH_CMP, (lo_q < mid_q) && (mid_q < hi_q), "bad search window")
	`BPI_ASSERT_NOW(a_div_rem_bound, state_q == S_DIV, rem_q < span_q, "divider remainder overflow")
	`BPI_ASSERT_NOW(a_nonquery_zero, (state_q == S_DONE) && (func_q != FN_QUERY), res_level_q == '0, "nonzero level on non-query")

endmodule
